FILE: design/wma_pkg.sv
// Shared constants and controller/datapath interface types for the weighted moving average.
package wma_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 7;
    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int TOT_W      = 40;
    localparam int ACC_W      = 46;
    localparam int MAG_W      = ACC_W - 1;
    localparam int PROD_W     = SAMPLE_W + LEN_W + 1;
    localparam int AVG_W      = 38;
    localparam int AVG_BYTES_W = 40;
    localparam int CNT_W      = $clog2(MAG_W);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(MAG_W - 1);

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic upd;
        logic div_step;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full_now;
    } status_t;

endpackage

FILE: design/wma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/wma_ctrl.sv
// Sequencing state machine: accept, multiply, update, divide (full window only), deliver.
module wma_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output wma_pkg::cmd_t   cmd,
    input  wma_pkg::status_t status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [wma_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd  = 1'b1;
                cnt_next = '0;
                state_next = status.full_now ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == wma_pkg::DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/wma_dp.sv
// Datapath: sample ring buffer, running sums, serial divider, result register.
module wma_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wma_pkg::cmd_t                       cmd,
    output wma_pkg::status_t                    status,
    input  logic [wma_pkg::SAMPLE_W-1:0]        sample,
    input  logic                                series_end,
    input  logic                                cfg_we,
    input  logic [wma_pkg::LEN_W-1:0]           cfg_len,
    output logic [wma_pkg::AVG_W-1:0]           average,
    output logic                                window_full,
    output logic                                too_short
);

    localparam int SW = wma_pkg::SAMPLE_W;
    localparam int LW = wma_pkg::LEN_W;
    localparam int AW = wma_pkg::ADDR_W;

    logic [LW-1:0]                    len_reg;
    logic [LW-1:0]                    seen_reg;
    logic [AW-1:0]                    wp_reg;
    logic signed [wma_pkg::TOT_W-1:0] tot_reg;
    logic signed [wma_pkg::ACC_W-1:0] acc_reg;
    logic signed [SW-1:0]             x_reg;
    logic signed [SW-1:0]             old_reg;
    logic signed [wma_pkg::PROD_W-1:0] prod_reg;
    logic                             end_reg;
    logic                             fullb_reg;
    logic                             full_reg;
    logic                             short_reg;
    logic                             neg_reg;
    logic [wma_pkg::MAG_W-1:0]        q_reg;
    logic [LW-1:0]                    rem_reg;
    logic [wma_pkg::AVG_W-1:0]        avg_reg;
    logic                             ofull_reg;
    logic                             oshort_reg;

    logic [LW-1:0]                    n_sat;
    logic [AW-1:0]                    rd_addr;
    logic [SW-1:0]                    ram_rdata;
    logic [LW-1:0]                    weight;
    logic signed [wma_pkg::PROD_W-1:0] prod_next;
    logic [LW-1:0]                    seen_inc;
    logic                             full_now;
    logic signed [wma_pkg::ACC_W-1:0] acc_next;
    logic signed [wma_pkg::TOT_W-1:0] tot_next;
    logic signed [wma_pkg::ACC_W-1:0] acc_abs;
    logic [LW:0]                      rem_sh;
    logic                             qbit;
    logic [wma_pkg::MAG_W-1:0]        q_signed;

    assign n_sat   = (len_reg > wma_pkg::LEN_MAX) ? wma_pkg::LEN_MAX : len_reg;
    assign rd_addr = wp_reg - n_sat[AW-1:0];   // oldest sample of the window

    wma_ram #(.WIDTH(SW), .DEPTH(wma_pkg::MAX_WINDOW)) u_ram (
        .clk   (clk),
        .we    (cmd.mul),
        .waddr (wp_reg),
        .wdata (x_reg),
        .re    (cmd.accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign weight    = fullb_reg ? (n_sat - 1'b1) : seen_reg;
    assign prod_next = x_reg * $signed({1'b0, weight});

    assign seen_inc = (seen_reg == wma_pkg::LEN_MAX) ? seen_reg : seen_reg + 1'b1;
    assign full_now = (n_sat != '0) && (seen_inc >= n_sat);

    // sliding update with a full window: W' = W - (T - oldest) + (N-1)*newest; before that W' = W + seen*newest
    always_comb
    begin
        if (fullb_reg)
        begin
            acc_next = acc_reg - wma_pkg::ACC_W'(tot_reg) + wma_pkg::ACC_W'(old_reg)
                     + wma_pkg::ACC_W'(prod_reg);
            tot_next = tot_reg - wma_pkg::TOT_W'(old_reg) + wma_pkg::TOT_W'(x_reg);
        end
        else
        begin
            acc_next = acc_reg + wma_pkg::ACC_W'(prod_reg);
            tot_next = tot_reg + wma_pkg::TOT_W'(x_reg);
        end
    end

    assign acc_abs = acc_next[wma_pkg::ACC_W-1] ? -acc_next : acc_next;

    assign rem_sh = {rem_reg, q_reg[wma_pkg::MAG_W-1]};
    assign qbit   = (rem_sh >= {1'b0, n_sat});

    assign q_signed = neg_reg ? -q_reg : q_reg;

    assign status.full_now = full_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= wma_pkg::LEN_RESET;
            seen_reg <= '0;
            wp_reg   <= '0;
            tot_reg  <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg  <= cfg_len;
                seen_reg <= '0;
                tot_reg  <= '0;
                acc_reg  <= '0;
            end
            else if (cmd.upd)
            begin
                seen_reg <= end_reg ? '0 : seen_inc;
                tot_reg  <= end_reg ? '0 : tot_next;
                acc_reg  <= end_reg ? '0 : acc_next;
            end
            if (cmd.mul)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg     <= sample;
            end_reg   <= series_end;
            fullb_reg <= (n_sat != '0) && (seen_reg >= n_sat);
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            old_reg  <= ram_rdata;
        end
        if (cmd.upd)
        begin
            full_reg  <= full_now;
            short_reg <= end_reg && (seen_inc < n_sat);
            neg_reg   <= acc_next[wma_pkg::ACC_W-1];
            q_reg     <= acc_abs[wma_pkg::MAG_W-1:0];
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[wma_pkg::MAG_W-2:0], qbit};
            rem_reg <= qbit ? LW'(rem_sh - {1'b0, n_sat}) : rem_sh[LW-1:0];
        end
        if (cmd.load_out)
        begin
            avg_reg    <= full_reg ? q_signed[wma_pkg::AVG_W-1:0] : '0;
            ofull_reg  <= full_reg;
            oshort_reg <= short_reg;
        end
    end

    assign average     = avg_reg;
    assign window_full = ofull_reg;
    assign too_short   = oshort_reg;

endmodule

FILE: design/weighted_moving_average_core.sv
// Top level of the linearly weighted moving average over Q16.16 samples.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata = sample, tlast = series_end
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata = average, tuser = flags
// cfg       in   cfg_wr_en                     cfg_wr_data = window_len
//
// One beat in, one beat out. After acceptance a beat passes through the multiply
// and update states; when the window is full, the divide by N then runs one
// quotient bit per cycle through a restoring divider (45 steps) before the result loads.
// The next beat is taken the cycle after the result loads.
// Only one beat is in flight; the result register lets the next beat in
// while a finished result waits for m_axis_tready.
// Reset clears all control state and sets window_len to 8; the sample RAM
// needs no clearing since only samples of the current series are read.
module weighted_moving_average_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wma_pkg::SAMPLE_W-1:0]    s_axis_tdata,    // [31:0] sample
    input  logic                            s_axis_tlast,    // series_end
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wma_pkg::AVG_BYTES_W-1:0] m_axis_tdata,    // [37:0] average, zero pad
    output logic [1:0]                      m_axis_tuser,    // [0] window_full, [1] too_short
    input  logic                            cfg_wr_en,
    input  logic [wma_pkg::LEN_W-1:0]       cfg_wr_data      // window_len
);

    wma_pkg::cmd_t    cmd;
    wma_pkg::status_t status;
    logic [wma_pkg::AVG_W-1:0] average;
    logic                      window_full;
    logic                      too_short;

    wma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    wma_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (s_axis_tdata),
        .series_end  (s_axis_tlast),
        .cfg_we      (cfg_wr_en),
        .cfg_len     (cfg_wr_data),
        .average     (average),
        .window_full (window_full),
        .too_short   (too_short)
    );

    // average sign-extended is not wanted: pad bits are zero
    assign m_axis_tdata = {{(wma_pkg::AVG_BYTES_W - wma_pkg::AVG_W){1'b0}}, average};
    assign m_axis_tuser = {too_short, window_full};

    // one beat in flight: after an accept the input side closes
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a beat is in flight");

    // warm-up results carry a zero average
    a_warmup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero average without a full window");

    // a full window and a short series exclude each other
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("window_full and too_short both set");

endmodule
